// File: design/critical_path_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Critical path scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRITICAL_PATH_SCHEDULER_MACROS_SVH
`define CRITICAL_PATH_SCHEDULER_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define CPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that forces an outcome in the next cycle
`define CPS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: design/cps_pkg.sv
// ----------------------------------------------------------------------------
// Critical path scheduler package
// Sizes, action and status codes shared by the scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

    localparam int MAX_TASKS = 32;
    localparam int TASK_BITS = $clog2(MAX_TASKS);
    localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
    localparam int DUR_BITS  = 16;
    localparam int DATE_BITS = 21;

    localparam logic [DATE_BITS-1:0] DATE_MAX = {DATE_BITS{1'b1}};

    // Input actions
    localparam logic [1:0] ACT_SET_DUR = 2'd0;
    localparam logic [1:0] ACT_ADD_ARC = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_CIRCUIT = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    typedef logic [MAX_TASKS-1:0] task_mask_t;
    typedef logic [DATE_BITS-1:0] date_t;

endpackage

`default_nettype wire

// File: design/critical_path_scheduler.sv
// ----------------------------------------------------------------------------
// Critical path scheduler
// Stores task durations and precedence arcs, refuses arcs that close a
// circuit and computes earliest and latest start dates for every task.
// ----------------------------------------------------------------------------
// The block takes one item at a time and is not ready while it works. An add
// arc item walks reachability from the dependent task, one node expanded per
// cycle, over every stored arc, including arcs of tasks at or above the
// current count. A compute item runs a topological pass that also pushes
// earliest dates, a reverse pass for latest dates, then delivers n results,
// one per cycle when the sink is ready. The walk and the topological pass
// share one lowest-bit picker; the topological pass uses one date adder
// and the reverse pass one date subtractor.
`default_nettype none

`include "critical_path_scheduler_macros.svh"

module critical_path_scheduler
    import cps_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    // Configuration: task_count
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [5:0]  cfg_data,
    // Input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // task_req[4:0], predecessor[9:5], duration[25:10]
    input  wire  [1:0]  s_axis_tuser,   // action[1:0]
    // Results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // task_index[4:0], earliest_start[25:5],
                                        // latest_start[46:26]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REACH,
        ST_FWD,
        ST_BWD,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [DUR_BITS-1:0]    dur_reg [MAX_TASKS];
    task_mask_t             row_reg [MAX_TASKS];
    logic [TASK_BITS-1:0]   tsk_reg;
    logic [TASK_BITS-1:0]   prd_reg;
    task_mask_t             visit_reg;
    task_mask_t             done_reg;
    task_mask_t             rem_reg;
    logic [TASK_BITS-1:0]   order_reg [MAX_TASKS];
    logic [CNT_BITS-1:0]    step_reg;
    date_t                  early_reg [MAX_TASKS];
    date_t                  late_reg [MAX_TASKS];
    date_t                  tend_reg;

    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [TASK_BITS-1:0]   out_idx_reg;
    date_t                  out_es_reg;
    date_t                  out_ls_reg;
    logic                   out_last_reg;

    // Input fields
    logic [1:0]             in_action;
    logic [TASK_BITS-1:0]   in_task;
    logic [TASK_BITS-1:0]   in_pred;
    logic [DUR_BITS-1:0]    in_dur;

    assign in_action = s_axis_tuser;
    assign in_task   = s_axis_tdata[4:0];
    assign in_pred   = s_axis_tdata[9:5];
    assign in_dur    = s_axis_tdata[25:10];

    // Effective task count, saturated to 1..MAX_TASKS
    logic [CNT_BITS-1:0]    n_eff;
    task_mask_t             real_mask;

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            n_eff = CNT_BITS'(1);
        end
        else if (cnt_reg > CNT_BITS'(MAX_TASKS))
        begin
            n_eff = CNT_BITS'(MAX_TASKS);
        end
        else
        begin
            n_eff = cnt_reg;
        end
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            real_mask[i] = (CNT_BITS'(i) < n_eff);
        end
    end

    // Roots of the remaining graph: no remaining predecessor
    task_mask_t             roots;

    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            logic has_pred;
            has_pred = 1'b0;
            for (int p = 0; p < MAX_TASKS; p++)
            begin
                has_pred = has_pred | (rem_reg[p] & row_reg[p][i]);
            end
            roots[i] = rem_reg[i] & ~has_pred;
        end
    end

    // Shared picker: pending node in the walk, or next root in the pass
    task_mask_t             pick_mask;
    logic [TASK_BITS-1:0]   pick_idx;
    logic                   pick_any;

    assign pick_mask = (state_reg == ST_REACH) ? (visit_reg & ~done_reg) : roots;

    cps_lsb u_pick (
        .mask (pick_mask),
        .idx  (pick_idx),
        .any  (pick_any)
    );

    // Forward date of the picked node, saturating
    logic [DATE_BITS:0]     fwd_sum;
    date_t                  fwd_date;

    assign fwd_sum  = {1'b0, early_reg[pick_idx]}
                    + (DATE_BITS + 1)'(dur_reg[pick_idx]);
    assign fwd_date = fwd_sum[DATE_BITS] ? DATE_MAX : fwd_sum[DATE_BITS-1:0];

    // Backward date of the node at the current order slot, floored at zero
    logic [TASK_BITS-1:0]   bwd_node;
    date_t                  bwd_dur;
    date_t                  bwd_date;

    assign bwd_node = order_reg[TASK_BITS'(step_reg - CNT_BITS'(1))];
    assign bwd_dur  = DATE_BITS'(dur_reg[bwd_node]);
    assign bwd_date = (late_reg[bwd_node] > bwd_dur) ? (late_reg[bwd_node] - bwd_dur) : '0;

    // Emit slot
    logic [TASK_BITS-1:0]   emit_idx;
    assign emit_idx = step_reg[TASK_BITS-1:0];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_ls_reg, out_es_reg, out_idx_reg};

    // Sequencer, stores and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= CNT_BITS'(MAX_TASKS);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                dur_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cnt_reg <= cfg_data;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        out_idx_reg  <= in_task;
                        out_es_reg   <= '0;
                        out_ls_reg   <= '0;
                        out_last_reg <= 1'b1;
                        tsk_reg      <= in_task;
                        prd_reg      <= in_pred;
                        case (in_action)
                            ACT_SET_DUR:
                            begin
                                if (CNT_BITS'(in_task) >= n_eff)
                                begin
                                    out_status_reg <= STAT_RANGE;
                                end
                                else
                                begin
                                    out_status_reg   <= STAT_OK;
                                    dur_reg[in_task] <= in_dur;
                                end
                                out_valid_reg <= 1'b1;
                                state_reg     <= ST_OUT;
                            end
                            ACT_ADD_ARC:
                            begin
                                if (CNT_BITS'(in_task) >= n_eff
                                    || CNT_BITS'(in_pred) >= n_eff)
                                begin
                                    out_status_reg <= STAT_RANGE;
                                    out_valid_reg  <= 1'b1;
                                    state_reg      <= ST_OUT;
                                end
                                else if (in_task == in_pred)
                                begin
                                    out_status_reg <= STAT_CIRCUIT;
                                    out_valid_reg  <= 1'b1;
                                    state_reg      <= ST_OUT;
                                end
                                else
                                begin
                                    visit_reg <= row_reg[in_task];
                                    done_reg  <= '0;
                                    state_reg <= ST_REACH;
                                end
                            end
                            ACT_COMPUTE:
                            begin
                                rem_reg  <= real_mask;
                                step_reg <= '0;
                                tend_reg <= '0;
                                for (int i = 0; i < MAX_TASKS; i++)
                                begin
                                    early_reg[i] <= '0;
                                end
                                state_reg <= ST_FWD;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // Does the dependent task reach the predecessor?
                ST_REACH:
                begin
                    if (visit_reg[prd_reg])
                    begin
                        out_status_reg <= STAT_CIRCUIT;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_OUT;
                    end
                    else if (!pick_any)
                    begin
                        row_reg[prd_reg][tsk_reg] <= 1'b1;
                        out_status_reg <= STAT_OK;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        done_reg[pick_idx] <= 1'b1;
                        visit_reg          <= visit_reg | row_reg[pick_idx];
                    end
                end

                // Topological order, pushing earliest dates to successors
                ST_FWD:
                begin
                    if (!pick_any)
                    begin
                        for (int i = 0; i < MAX_TASKS; i++)
                        begin
                            late_reg[i] <= tend_reg;
                        end
                        state_reg <= ST_BWD;
                    end
                    else
                    begin
                        order_reg[TASK_BITS'(step_reg)] <= pick_idx;
                        step_reg          <= step_reg + CNT_BITS'(1);
                        rem_reg[pick_idx] <= 1'b0;
                        if (fwd_date > tend_reg)
                        begin
                            tend_reg <= fwd_date;
                        end
                        for (int s = 0; s < MAX_TASKS; s++)
                        begin
                            if (row_reg[pick_idx][s] && real_mask[s]
                                && fwd_date > early_reg[s])
                            begin
                                early_reg[s] <= fwd_date;
                            end
                        end
                    end
                end

                // Reverse order, pulling latest dates into predecessors
                ST_BWD:
                begin
                    if (step_reg == '0)
                    begin
                        out_status_reg <= STAT_OK;
                        out_idx_reg    <= emit_idx;
                        out_es_reg     <= early_reg[emit_idx];
                        out_ls_reg     <= late_reg[emit_idx];
                        out_last_reg   <= (n_eff == CNT_BITS'(1));
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        late_reg[bwd_node] <= bwd_date;
                        for (int p = 0; p < MAX_TASKS; p++)
                        begin
                            if (row_reg[p][bwd_node] && real_mask[p]
                                && bwd_date < late_reg[p])
                            begin
                                late_reg[p] <= bwd_date;
                            end
                        end
                        step_reg <= step_reg - CNT_BITS'(1);
                    end
                end

                // Result waits for the sink; next schedule result follows
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (out_last_reg)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            out_idx_reg  <= TASK_BITS'(step_reg + CNT_BITS'(1));
                            out_es_reg   <= early_reg[TASK_BITS'(step_reg + CNT_BITS'(1))];
                            out_ls_reg   <= late_reg[TASK_BITS'(step_reg + CNT_BITS'(1))];
                            out_last_reg <= (step_reg + CNT_BITS'(2) == n_eff);
                            step_reg     <= step_reg + CNT_BITS'(1);
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `CPS_ASSERT(a_no_overlap, !(s_axis_tready && m_axis_tvalid),
        "input ready while a result is pending")
    `CPS_ASSERT(a_err_last, (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> m_axis_tlast,
        "error result not marked last")
    `CPS_ASSERT_NEXT(a_busy_after_take,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_UNUSED), !s_axis_tready,
        "still ready after taking an item")
    `CPS_ASSERT(a_count_nonzero, n_eff != '0, "effective task count is zero")

endmodule

`default_nettype wire

// File: design/cps_lsb.sv
// ----------------------------------------------------------------------------
// Lowest set bit picker
// Returns the index of the lowest set bit of a task mask and a found flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_lsb
    import cps_pkg::*;
(
    input  wire task_mask_t           mask,
    output logic [TASK_BITS-1:0]      idx,
    output logic                      any
);

    // Priority encode, lowest index wins
    always_comb
    begin
        idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = TASK_BITS'(i);
            end
        end
        any = |mask;
    end

endmodule

`default_nettype wire

// File: test/critical_path_scheduler_checker.sv
// ----------------------------------------------------------------------------
// Critical path scheduler result checker
// Watches the config, input and result channels, keeps its own copy of the
// task store and arc matrix, predicts every result and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module critical_path_scheduler_checker
    import cps_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [5:0]  cfg_data,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [31:0] s_axis_tdata,
    input  wire  [1:0]  s_axis_tuser,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [47:0] m_axis_tdata,
    input  wire  [1:0]  m_axis_tuser,
    input  wire         m_axis_tlast,
    output int          fail_count,
    output int          pending
);

    localparam int NODES     = MAX_TASKS + 2;
    localparam int START_IDX = MAX_TASKS;
    localparam int END_IDX   = MAX_TASKS + 1;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  task_index;
        date_t       earliest;
        date_t       latest;
        logic        last;
    } sched_result_t;

    sched_result_t          expected_results[$];
    logic [DUR_BITS-1:0]    task_dur[MAX_TASKS];
    logic [NODES-1:0]       arcs[NODES];
    logic [5:0]             task_count_reg;

    assign pending = expected_results.size();

    function automatic int used_tasks();
        int n;
        n = task_count_reg;
        if (n < 1) n = 1;
        if (n > MAX_TASKS) n = MAX_TASKS;
        return n;
    endfunction

    // Depth-first reachability from origin back to itself
    function automatic bit reaches_itself(int origin);
        logic [NODES-1:0] seen;
        int               stack[NODES];
        int               sp;
        int               v;
        seen = '0;
        sp = 0;
        v = origin;
        forever
        begin
            for (int j = 0; j < NODES; j++)
            begin
                if (arcs[v][j] && !seen[j])
                begin
                    if (j == origin) return 1'b1;
                    seen[j] = 1'b1;
                    if (sp < NODES)
                    begin
                        stack[sp] = j;
                        sp++;
                    end
                end
            end
            if (sp == 0) return 1'b0;
            sp--;
            v = stack[sp];
        end
    endfunction

    // Leveling, forward earliest dates and backward latest dates
    task automatic predict_schedule();
        int               n;
        int               maxlv;
        logic [NODES-1:0] real_m;
        logic [NODES-1:0] used;
        logic [NODES-1:0] removed;
        logic [NODES-1:0] left;
        logic [NODES-1:0] roots;
        logic [NODES-1:0] work[NODES];
        longint           dur[NODES];
        int               lvl[NODES];
        longint           es[NODES];
        longint           ls[NODES];
        longint           tend;
        longint           t;
        longint           m;
        bit               has_pred;
        bit               root;
        bit               first;
        sched_result_t    r;
        n = used_tasks();
        maxlv = 0;
        tend = 0;
        real_m = '0;
        for (int i = 0; i < n; i++) real_m[i] = 1'b1;
        used = real_m;
        used[START_IDX] = 1'b1;
        used[END_IDX] = 1'b1;
        for (int i = 0; i < NODES; i++)
        begin
            work[i] = (i < n) ? (arcs[i] & real_m) : '0;
            dur[i] = (i < n) ? task_dur[i] : 0;
            lvl[i] = 0;
            es[i] = 0;
            ls[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            has_pred = 1'b0;
            for (int j = 0; j < n; j++)
                if (work[j][i]) has_pred = 1'b1;
            if (!has_pred) work[START_IDX][i] = 1'b1;
        end
        for (int i = 0; i < n; i++)
            if ((work[i] & real_m) == '0) work[i][END_IDX] = 1'b1;
        removed = '0;
        for (int lv = 0; removed != used && lv < NODES; lv++)
        begin
            left = used & ~removed;
            roots = '0;
            for (int i = 0; i < NODES; i++)
            begin
                if (!left[i]) continue;
                root = 1'b1;
                for (int j = 0; j < NODES; j++)
                    if (left[j] && work[j][i]) root = 1'b0;
                if (root)
                begin
                    roots[i] = 1'b1;
                    lvl[i] = lv;
                    maxlv = lv;
                end
            end
            if (roots == '0) break;
            removed |= roots;
        end
        for (int lv = 0; lv <= maxlv; lv++)
            for (int i = 0; i < NODES; i++)
            begin
                if (!used[i] || lvl[i] != lv) continue;
                m = 0;
                for (int j = 0; j < NODES; j++)
                    if (used[j] && work[j][i])
                    begin
                        t = es[j] + dur[j];
                        if (t > DATE_MAX) t = DATE_MAX;
                        if (t > m) m = t;
                    end
                es[i] = m;
                if (m > tend) tend = m;
            end
        for (int lv = maxlv; lv >= 0; lv--)
            for (int i = 0; i < NODES; i++)
            begin
                if (!used[i] || lvl[i] != lv) continue;
                if (lv == maxlv)
                begin
                    ls[i] = tend;
                    continue;
                end
                m = tend;
                first = 1'b1;
                for (int j = 0; j < NODES; j++)
                    if (used[j] && work[i][j])
                    begin
                        if (first || ls[j] < m) m = ls[j];
                        first = 1'b0;
                    end
                ls[i] = (m > dur[i]) ? m - dur[i] : 0;
            end
        for (int k = 0; k < n; k++)
        begin
            r.status = STAT_OK;
            r.task_index = k[4:0];
            r.earliest = date_t'(es[k]);
            r.latest = date_t'(ls[k]);
            r.last = (k == n - 1);
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    task automatic predict_item(logic [1:0] act, logic [4:0] tsk, logic [4:0] pred,
                                logic [15:0] dur);
        sched_result_t r;
        int            n;
        bit            had;
        n = used_tasks();
        r = '0;
        r.task_index = tsk;
        r.last = 1'b1;
        r.status = STAT_OK;
        if (act == ACT_COMPUTE)
        begin
            predict_schedule();
            return;
        end
        if (act != ACT_SET_DUR && act != ACT_ADD_ARC) return;
        if (tsk >= n || (act == ACT_ADD_ARC && pred >= n))
            r.status = STAT_RANGE;
        else if (act == ACT_SET_DUR)
            task_dur[tsk] = dur;
        else
        begin
            had = arcs[pred][tsk];
            arcs[pred][tsk] = 1'b1;
            if (reaches_itself(pred))
            begin
                if (!had) arcs[pred][tsk] = 1'b0;
                r.status = STAT_CIRCUIT;
            end
        end
        expected_results.insert(expected_results.size(), r);
    endtask

    // Track transfers on every channel
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            expected_results.delete();
            task_count_reg = 6'd32;
            for (int i = 0; i < MAX_TASKS; i++) task_dur[i] = '0;
            for (int i = 0; i < NODES; i++) arcs[i] = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) task_count_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[9:5],
                             s_axis_tdata[25:10]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result task_index %0d", m_axis_tdata[4:0]);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (m_axis_tuser != e.status)
                    begin
                        $error("status: expected %0d actual %0d", e.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[4:0] != e.task_index)
                    begin
                        $error("task_index: expected %0d actual %0d", e.task_index,
                               m_axis_tdata[4:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[25:5] != e.earliest)
                    begin
                        $error("earliest_start: expected %0d actual %0d", e.earliest,
                               m_axis_tdata[25:5]);
                        fail_count++;
                    end
                    if (m_axis_tdata[46:26] != e.latest)
                    begin
                        $error("latest_start: expected %0d actual %0d", e.latest,
                               m_axis_tdata[46:26]);
                        fail_count++;
                    end
                    if (m_axis_tlast != e.last)
                    begin
                        $error("last: expected %0d actual %0d", e.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: test/critical_path_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Critical path scheduler testbench
// Drives directed and random duration, arc and compute items across several
// task counts with random gaps and sink stalls; a checker compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module critical_path_scheduler_tb;
    import cps_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    bit          stim_done;

    critical_path_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    critical_path_scheduler_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sink stalls: random wait before each acceptance
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 4);
            repeat (stall) @(negedge clk);
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
            m_axis_tready = 1'b0;
        end
    end

    task automatic send_item(logic [1:0] act, logic [4:0] tsk, logic [4:0] pred,
                             logic [15:0] dur);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(negedge clk);
        s_axis_tuser = act;
        s_axis_tdata = {6'd0, dur, pred, tsk};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Let the block drain before touching the task count
    task automatic write_count(logic [5:0] value);
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random forward arcs and durations, some stray items, then a final compute
    task automatic random_project(int n, int items);
        int a;
        int b;
        for (int k = 0; k < items; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(ACT_SET_DUR, 5'($urandom_range(0, n - 1)), 5'($urandom),
                                   16'($urandom));
                3, 4, 5, 6:
                begin
                    a = $urandom_range(0, n - 1);
                    b = $urandom_range(0, n - 1);
                    send_item(ACT_ADD_ARC, 5'(a > b ? a : b), 5'(a > b ? b : a), 16'($urandom));
                end
                7: send_item(ACT_ADD_ARC, 5'($urandom), 5'($urandom), 16'($urandom));
                8: send_item(2'($urandom), 5'($urandom), 5'($urandom), 16'($urandom));
                default: send_item(ACT_COMPUTE, 5'($urandom), 5'($urandom), 16'($urandom));
            endcase
        end
        send_item(ACT_COMPUTE, 5'd0, 5'd0, 16'd0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        stim_done = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, self arc, repeat arc, circuit, unused action
        send_item(ACT_COMPUTE, 5'd0, 5'd0, 16'd0);
        send_item(ACT_SET_DUR, 5'd31, 5'd0, 16'hFFFF);
        send_item(ACT_SET_DUR, 5'd0, 5'd31, 16'h0001);
        send_item(ACT_ADD_ARC, 5'd3, 5'd3, 16'd0);
        send_item(ACT_ADD_ARC, 5'd31, 5'd0, 16'd0);
        send_item(ACT_ADD_ARC, 5'd31, 5'd0, 16'd0);
        send_item(ACT_ADD_ARC, 5'd0, 5'd31, 16'd0);
        send_item(ACT_UNUSED, 5'd5, 5'd6, 16'h1234);
        send_item(ACT_COMPUTE, 5'd0, 5'd0, 16'd0);
        write_count(6'd4);
        send_item(ACT_SET_DUR, 5'd4, 5'd0, 16'd7);
        send_item(ACT_ADD_ARC, 5'd1, 5'd9, 16'd0);
        send_item(ACT_ADD_ARC, 5'd1, 5'd0, 16'd0);
        send_item(ACT_SET_DUR, 5'd0, 5'd0, 16'd5);
        send_item(ACT_SET_DUR, 5'd1, 5'd0, 16'd3);
        send_item(ACT_COMPUTE, 5'd0, 5'd0, 16'd0);
        write_count(6'd0);
        send_item(ACT_SET_DUR, 5'd1, 5'd0, 16'd2);
        send_item(ACT_COMPUTE, 5'd0, 5'd0, 16'd0);
        write_count(6'd63);
        send_item(ACT_COMPUTE, 5'd0, 5'd0, 16'd0);

        // Random phases across task counts
        write_count(6'd8);
        random_project(8, 40);
        write_count(6'd2);
        random_project(2, 20);
        write_count(6'($urandom_range(3, 16)));
        random_project(12, 40);
        write_count(6'd32);
        random_project(32, 40);
        write_count(6'd1);
        random_project(1, 10);

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        stim_done = 1'b1;
    end

    // Verdict
    initial
    begin
        wait (stim_done);
        if (fail_count == 0)
            $display("critical_path_scheduler: match");
        else
            $display("critical_path_scheduler: mismatch");
        $finish;
    end

    // Timeout
    initial
    begin
        #20ms;
        $display("critical_path_scheduler: mismatch");
        $finish;
    end

endmodule

// File: critical_path_scheduler.f
+incdir+design
design/cps_pkg.sv
design/cps_lsb.sv
design/critical_path_scheduler.sv
test/critical_path_scheduler_checker.sv
test/critical_path_scheduler_tb.sv
